// ----- design/tls_pkg.sv -----
`default_nettype none

package tls_pkg;

  // field and register widths
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned LAMP_W         = 6;
  localparam int unsigned REG_IDX_W      = 3;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // lamp patterns: bits 5..3 head a red/yellow/green, bits 2..0 head b
  localparam logic [LAMP_W-1:0] LAMPS_OFF = 6'b000000;
  localparam logic [LAMP_W-1:0] LAMPS_YY  = 6'b010010;
  localparam logic [LAMP_W-1:0] LAMPS_RG  = 6'b100001;
  localparam logic [LAMP_W-1:0] LAMPS_RY  = 6'b100010;
  localparam logic [LAMP_W-1:0] LAMPS_GR  = 6'b001100;
  localparam logic [LAMP_W-1:0] LAMPS_YR  = 6'b010100;

  // register reset values
  localparam logic [CFG_W-1:0] SHORT_TICKS_RST      = 16'd3000;
  localparam logic [CFG_W-1:0] LONG_TICKS_RST       = 16'd10000;
  localparam logic [CFG_W-1:0] FLASH_TICKS_RST      = 16'd249;
  localparam logic [CFG_W-1:0] HEARTBEAT_PERIOD_RST = 16'd999;
  localparam logic [CFG_W-1:0] HEARTBEAT_ON_RST     = 16'd200;

  // register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SHORT_TICKS      = 3'd0,
    REG_LONG_TICKS       = 3'd1,
    REG_FLASH_TICKS      = 3'd2,
    REG_HEARTBEAT_PERIOD = 3'd3,
    REG_HEARTBEAT_ON     = 3'd4
  } tls_reg_e;

  // configuration seen by the sequencer core
  typedef struct packed {
    logic [CFG_W-1:0] short_ticks;
    logic [CFG_W-1:0] long_ticks;
    logic [CFG_W-1:0] flash_ticks;
    logic [CFG_W-1:0] heartbeat_period;
    logic [CFG_W-1:0] heartbeat_on;
  } tls_cfg_t;

  // one result word
  typedef struct packed {
    logic [LAMP_W-1:0] lamps;
    logic              heartbeat;
    logic              alert_mode;
  } tls_result_t;

endpackage

`default_nettype wire

// ----- design/traffic_light_sequencer.sv -----
// Traffic light sequencer with alert flashing and heartbeat.
// Input channel (in_valid_i / in_ready_o) carries one word per millisecond
// tick: tick_i = 1 advances all counters, tick_i = 0 only reports the
// current lamps. button_i = 1 runs the normal cycle, 0 flashes yellow.
// Output channel (out_valid_o / out_ready_i) returns exactly one word per
// input word: lamps_o, heartbeat_o and alert_mode_o.
// A word lands in the input register, then the next-state logic updates
// the sequencer state and loads the result register. Throughput is one
// word per cycle while the receiver takes results.
// A stalled receiver holds the result register; the input register still
// takes one more word, after which in_ready_o drops until the result moves.
// Reset clears both stages, puts all lamps off, heartbeat off, alert mode
// on, and loads the default tick limits. Limits are written through the
// cfg_we_i / cfg_idx_i / cfg_wdata_i port; the user must write them only
// while no word is in flight, which the block does not enforce.
`default_nettype none

module traffic_light_sequencer
  import tls_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic                 tick_i,
  input  wire logic                 button_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic [LAMP_W-1:0]    lamps_o,
  output      logic                 heartbeat_o,
  output      logic                 alert_mode_o
);

  tls_cfg_t    cfg;
  tls_result_t res;
  tls_result_t res_q;
  logic        in_vld_q, in_vld_d;
  logic        out_vld_q, out_vld_d;
  logic        tick_q, button_q;
  logic        adv;
  logic        in_take;

  // configuration registers
  tls_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // handshake between input register and result register
  assign adv        = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | adv;
  assign in_take    = in_valid_i & in_ready_o;
  assign in_vld_d   = in_take | (in_vld_q & ~adv);
  assign out_vld_d  = adv | (out_vld_q & ~out_ready_i);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tick_q   <= tick_i;
      button_q <= button_i;
    end
  end

  // sequencer state and next-state logic
  tls_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .adv_i    (adv),
    .tick_i   (tick_q),
    .button_i (button_q),
    .res_o    (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign lamps_o      = res_q.lamps;
  assign heartbeat_o  = res_q.heartbeat;
  assign alert_mode_o = res_q.alert_mode;

endmodule

`default_nettype wire

// ----- design/tls_cfg_regs.sv -----
`default_nettype none

module tls_cfg_regs
  import tls_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output tls_cfg_t                  cfg_o
);

  tls_cfg_t cfg_q, cfg_d;
  tls_reg_e idx;

  assign idx = tls_reg_e'(cfg_idx_i);

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (idx)
        REG_SHORT_TICKS:      cfg_d.short_ticks      = cfg_wdata_i;
        REG_LONG_TICKS:       cfg_d.long_ticks       = cfg_wdata_i;
        REG_FLASH_TICKS:      cfg_d.flash_ticks      = cfg_wdata_i;
        REG_HEARTBEAT_PERIOD: cfg_d.heartbeat_period = cfg_wdata_i;
        REG_HEARTBEAT_ON:     cfg_d.heartbeat_on     = cfg_wdata_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_ticks      <= SHORT_TICKS_RST;
      cfg_q.long_ticks       <= LONG_TICKS_RST;
      cfg_q.flash_ticks      <= FLASH_TICKS_RST;
      cfg_q.heartbeat_period <= HEARTBEAT_PERIOD_RST;
      cfg_q.heartbeat_on     <= HEARTBEAT_ON_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/tls_core.sv -----
`default_nettype none

module tls_core
  import tls_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire tls_cfg_t cfg_i,
  input  wire logic     adv_i,
  input  wire logic     tick_i,
  input  wire logic     button_i,
  output tls_result_t   res_o
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  typedef enum logic [4:0] {
    PH_RESTART = 5'b00001,
    PH_RG_WAIT = 5'b00010,
    PH_RY_WAIT = 5'b00100,
    PH_GR_WAIT = 5'b01000,
    PH_YR_WAIT = 5'b10000
  } tls_phase_e;

  typedef enum logic [2:0] {
    FL_START = 3'b001,
    FL_LIT   = 3'b010,
    FL_DARK  = 3'b100
  } tls_flash_e;

  logic                   button_last_q, button_last_d;
  tls_phase_e             phase_q, phase_d, phase_eff;
  logic [COUNT_WIDTH-1:0] phase_cnt_q, phase_cnt_d, phase_cnt_inc;
  tls_flash_e             flash_q, flash_d;
  logic [COUNT_WIDTH-1:0] flash_cnt_q, flash_cnt_d, flash_cnt_inc;
  logic [COUNT_WIDTH-1:0] beat_cnt_q, beat_cnt_d, beat_cnt_inc;
  logic [LAMP_W-1:0]      lamps_q, lamps_d;
  logic                   beat_led_q, beat_led_d;
  logic [CFG_W-1:0]       phase_limit;
  logic                   phase_over, flash_over, beat_over;

  assign phase_cnt_inc = phase_cnt_q + 1'b1;
  assign flash_cnt_inc = flash_cnt_q + 1'b1;
  assign beat_cnt_inc  = beat_cnt_q + 1'b1;

  // odd phases use the short limit, even ones the long limit
  assign phase_limit = (phase_q == PH_RG_WAIT || phase_q == PH_GR_WAIT) ?
                       cfg_i.short_ticks : cfg_i.long_ticks;
  assign phase_over  = CMP_W'(phase_cnt_inc) > CMP_W'(phase_limit);
  assign flash_over  = CMP_W'(flash_cnt_inc) > CMP_W'(cfg_i.flash_ticks);
  assign beat_over   = CMP_W'(beat_cnt_q) > CMP_W'(cfg_i.heartbeat_period);

  // next state for one word
  always_comb begin
    button_last_d = button_last_q;
    phase_d       = phase_q;
    phase_eff     = phase_q;
    phase_cnt_d   = phase_cnt_q;
    flash_d       = flash_q;
    flash_cnt_d   = flash_cnt_q;
    beat_cnt_d    = beat_cnt_q;
    lamps_d       = lamps_q;
    beat_led_d    = beat_led_q;
    if (tick_i) begin
      // button level change, rising level restarts the sequence
      if (button_i != button_last_q) begin
        button_last_d = button_i;
        if (button_i) begin
          phase_eff = PH_RESTART;
        end
      end

      if (button_last_d) begin
        // normal run
        unique case (phase_eff)
          PH_RG_WAIT, PH_RY_WAIT, PH_GR_WAIT, PH_YR_WAIT: begin
            phase_cnt_d = phase_cnt_inc;
            if (phase_over) begin
              phase_cnt_d = '0;
              unique case (phase_eff)
                PH_RG_WAIT: begin
                  lamps_d = LAMPS_RG;
                  phase_d = PH_RY_WAIT;
                end
                PH_RY_WAIT: begin
                  lamps_d = LAMPS_RY;
                  phase_d = PH_GR_WAIT;
                end
                PH_GR_WAIT: begin
                  lamps_d = LAMPS_GR;
                  phase_d = PH_YR_WAIT;
                end
                default: begin
                  lamps_d = LAMPS_YR;
                  phase_d = PH_RG_WAIT;
                end
              endcase
            end
          end
          default: begin
            phase_cnt_d = '0;
            lamps_d     = LAMPS_YY;
            phase_d     = PH_RG_WAIT;
          end
        endcase
      end else begin
        // alert flashing
        unique case (flash_q)
          FL_LIT, FL_DARK: begin
            flash_cnt_d = flash_cnt_inc;
            if (flash_over) begin
              flash_cnt_d = '0;
              if (flash_q == FL_LIT) begin
                lamps_d = LAMPS_OFF;
                flash_d = FL_DARK;
              end else begin
                lamps_d = LAMPS_YY;
                flash_d = FL_LIT;
              end
            end
          end
          default: begin
            flash_cnt_d = '0;
            flash_d     = FL_LIT;
          end
        endcase
      end

      // heartbeat
      beat_cnt_d = beat_cnt_inc;
      if (beat_over) begin
        beat_cnt_d = '0;
        beat_led_d = 1'b1;
      end
      if (CMP_W'(beat_cnt_d) == CMP_W'(cfg_i.heartbeat_on)) begin
        beat_led_d = 1'b0;
      end
    end
  end

  // state registers, advanced once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_last_q <= 1'b0;
      phase_q       <= PH_RESTART;
      phase_cnt_q   <= '0;
      flash_q       <= FL_START;
      flash_cnt_q   <= '0;
      beat_cnt_q    <= '0;
      lamps_q       <= LAMPS_OFF;
      beat_led_q    <= 1'b0;
    end else if (adv_i) begin
      button_last_q <= button_last_d;
      phase_q       <= phase_d;
      phase_cnt_q   <= phase_cnt_d;
      flash_q       <= flash_d;
      flash_cnt_q   <= flash_cnt_d;
      beat_cnt_q    <= beat_cnt_d;
      lamps_q       <= lamps_d;
      beat_led_q    <= beat_led_d;
    end
  end

  // result from the updated state
  assign res_o.lamps      = lamps_d;
  assign res_o.heartbeat  = beat_led_d;
  assign res_o.alert_mode = ~button_last_d;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import tls_pkg::*;

  localparam int unsigned CNT_W        = COUNT_WIDTH_DEF;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;

  // write indexes past the last register, ignored by the block
  localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(REG_HEARTBEAT_ON) + 1'b1;
  localparam logic [REG_IDX_W-1:0] REG_TOP   = {REG_IDX_W{1'b1}};

  // normal sequence steps, named after the lamps shown when the step ends
  localparam logic [2:0] SEQ_START = 3'd0;
  localparam logic [2:0] SEQ_TO_RG = 3'd1;
  localparam logic [2:0] SEQ_TO_RY = 3'd2;
  localparam logic [2:0] SEQ_TO_GR = 3'd3;
  localparam logic [2:0] SEQ_TO_YR = 3'd4;

  // alert flashing halves
  localparam logic [1:0] BLINK_START = 2'd0;
  localparam logic [1:0] BLINK_LIT   = 2'd1;
  localparam logic [1:0] BLINK_DARK  = 2'd2;

  typedef enum logic [1:0] {ROW_WORD, ROW_KNOWN, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic                 tick;
    logic                 button;
    logic [REG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     value;
    tls_result_t          known;
  } stim_row_t;

  typedef struct {
    logic             btn_level;
    logic [2:0]       seq_step;
    logic [CNT_W-1:0] seq_count;
    logic [1:0]       blink;
    logic [CNT_W-1:0] blink_count;
    logic [CNT_W-1:0] beat_count;
    logic [LAMP_W-1:0] lamps;
    logic             beat;
  } light_state_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 tick_i      = 1'b0;
  logic                 button_i    = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [LAMP_W-1:0]    lamps_o;
  logic                 heartbeat_o;
  logic                 alert_mode_o;

  traffic_light_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .tick_i       (tick_i),
    .button_i     (button_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .lamps_o      (lamps_o),
    .heartbeat_o  (heartbeat_o),
    .alert_mode_o (alert_mode_o)
  );

  // predictor state and its copy of the limits
  light_state_t lights;
  tls_cfg_t     limits;

  tls_result_t lamp_words_due[$];
  stim_row_t   directed_rows[$];

  int  mismatches    = 0;
  int  results_seen  = 0;
  int  words_sent    = 0;
  int  ticked_sent   = 0;
  int  settings_used = 0;
  bit  calm          = 1'b0;
  bit  hold_req      = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns: %s", $time, what);
  endtask

  // mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void reset_lights();
    lights.btn_level   = 1'b0;
    lights.seq_step    = SEQ_START;
    lights.seq_count   = '0;
    lights.blink       = BLINK_START;
    lights.blink_count = '0;
    lights.beat_count  = '0;
    lights.lamps       = LAMPS_OFF;
    lights.beat        = 1'b0;
    limits.short_ticks      = SHORT_TICKS_RST;
    limits.long_ticks       = LONG_TICKS_RST;
    limits.flash_ticks      = FLASH_TICKS_RST;
    limits.heartbeat_period = HEARTBEAT_PERIOD_RST;
    limits.heartbeat_on     = HEARTBEAT_ON_RST;
  endfunction

  // advance the predicted sequencer by one word and return its result
  function automatic tls_result_t predict_lights(input logic tick, input logic button);
    logic [CFG_W-1:0] limit;
    logic [CNT_W-1:0] prior_beat;
    if (tick) begin
      if (button != lights.btn_level) begin
        lights.btn_level = button;
        if (button) lights.seq_step = SEQ_START;
      end
      if (lights.btn_level) begin
        // normal cycle, unused step codes restart
        if (lights.seq_step == SEQ_START || lights.seq_step > SEQ_TO_YR) begin
          lights.seq_count = '0;
          lights.lamps     = LAMPS_YY;
          lights.seq_step  = SEQ_TO_RG;
        end else begin
          limit = lights.seq_step[0] ? limits.short_ticks : limits.long_ticks;
          lights.seq_count = lights.seq_count + 1'b1;
          if (lights.seq_count > limit) begin
            lights.seq_count = '0;
            case (lights.seq_step)
              SEQ_TO_RG: lights.lamps = LAMPS_RG;
              SEQ_TO_RY: lights.lamps = LAMPS_RY;
              SEQ_TO_GR: lights.lamps = LAMPS_GR;
              default:   lights.lamps = LAMPS_YR;
            endcase
            lights.seq_step = (lights.seq_step == SEQ_TO_YR) ? SEQ_TO_RG
                                                             : lights.seq_step + 1'b1;
          end
        end
      end else begin
        // alert flashing, the spare code acts as start
        if (lights.blink != BLINK_LIT && lights.blink != BLINK_DARK) begin
          lights.blink_count = '0;
          lights.blink       = BLINK_LIT;
        end else begin
          lights.blink_count = lights.blink_count + 1'b1;
          if (lights.blink_count > limits.flash_ticks) begin
            lights.blink_count = '0;
            if (lights.blink == BLINK_LIT) begin
              lights.lamps = LAMPS_OFF;
              lights.blink = BLINK_DARK;
            end else begin
              lights.lamps = LAMPS_YY;
              lights.blink = BLINK_LIT;
            end
          end
        end
      end
      // heartbeat: compare the old count, then the off point
      prior_beat        = lights.beat_count;
      lights.beat_count = prior_beat + 1'b1;
      if (prior_beat > limits.heartbeat_period) begin
        lights.beat_count = '0;
        lights.beat       = 1'b1;
      end
      if (lights.beat_count == limits.heartbeat_on) lights.beat = 1'b0;
    end
    return '{lamps: lights.lamps, heartbeat: lights.beat, alert_mode: ~lights.btn_level};
  endfunction

  function automatic stim_row_t row(input row_kind_e kind, input logic tick,
                                    input logic button, input logic [REG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] value, input tls_result_t known);
    return '{kind: kind, tick: tick, button: button, idx: idx, value: value, known: known};
  endfunction

  // one register write, taken at the next edge
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_SHORT_TICKS:      limits.short_ticks      = value;
      REG_LONG_TICKS:       limits.long_ticks       = value;
      REG_FLASH_TICKS:      limits.flash_ticks      = value;
      REG_HEARTBEAT_PERIOD: limits.heartbeat_period = value;
      REG_HEARTBEAT_ON:     limits.heartbeat_on     = value;
      default: ;
    endcase
  endtask

  // offer one word and wait for it to be taken
  task automatic send_word(input logic t, input logic b, input bit known_ok,
                           input tls_result_t known);
    int gap;
    tls_result_t predicted;
    gap = (calm || $urandom_range(0, 99) < 65) ? 0 : gap_len();
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i     <= t;
    button_i   <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = predict_lights(t, b);
    lamp_words_due.push_back(known_ok ? known : predicted);
    words_sent++;
    if (t) ticked_sent++;
  endtask

  // let every pending result drain before touching the registers
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (lamp_words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] short_v, input logic [CFG_W-1:0] long_v,
                               input logic [CFG_W-1:0] flash_v, input logic [CFG_W-1:0] period_v,
                               input logic [CFG_W-1:0] on_v);
    wait_drained();
    write_reg(REG_SHORT_TICKS, short_v);
    write_reg(REG_LONG_TICKS, long_v);
    write_reg(REG_FLASH_TICKS, flash_v);
    write_reg(REG_HEARTBEAT_PERIOD, period_v);
    write_reg(REG_HEARTBEAT_ON, on_v);
    write_reg(REG_IDX_W'($urandom_range(REG_SPARE, REG_TOP)), CFG_W'($urandom));
    settings_used++;
  endtask

  // random limit between one and hi
  function automatic logic [CFG_W-1:0] rand_lim(input int unsigned hi);
    return CFG_W'($urandom_range(1, hi));
  endfunction

  // runs of a steady button level with random ticks, some glitches
  task automatic run_random(input int ticked_target, input bit with_hold);
    int   ticked;
    int   run_len;
    bit   hold_done;
    logic level;
    logic t;
    logic b;
    ticked    = 0;
    hold_done = 1'b0;
    while (ticked < ticked_target) begin
      run_len = $urandom_range(1, 40);
      level   = ($urandom_range(0, 99) < 70);
      calm    = ($urandom_range(0, 99) < 15);
      repeat (run_len) begin
        t = ($urandom_range(0, 99) < 85);
        b = ($urandom_range(0, 99) < 4) ? ~level : level;
        if (with_hold && !hold_done && ticked >= ticked_target / 2) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        send_word(t, b, 1'b0, '0);
        if (t) ticked++;
      end
    end
    calm = 1'b0;
  endtask

  // result side: random stalls, one long hold on request, and the checks
  initial begin : receiver
    int stall_left;
    int hold_left;
    tls_result_t due;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        results_seen++;
        if (lamp_words_due.size() == 0) begin
          report_mismatch("result word with nothing pending");
        end else begin
          due = lamp_words_due.pop_front();
          if (lamps_o !== due.lamps)
            report_mismatch($sformatf("lamps %b, predicted %b", lamps_o, due.lamps));
          if (heartbeat_o !== due.heartbeat)
            report_mismatch($sformatf("heartbeat %b, predicted %b", heartbeat_o,
                                      due.heartbeat));
          if (alert_mode_o !== due.alert_mode)
            report_mismatch($sformatf("alert_mode %b, predicted %b", alert_mode_o,
                                      due.alert_mode));
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left = gap_len() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ends the run when no word moves on either side for too long
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_ready_o === 1'b1) ||
          (out_valid_o === 1'b1 && out_ready_i === 1'b1)) stuck = 0;
      else stuck++;
    end
    $display("timeout: no word moved for %0d cycles, %0d results pending", STALL_LIMIT,
             lamp_words_due.size());
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    bit settled;
    reset_lights();
    // after reset with default limits
    directed_rows.push_back(row(ROW_KNOWN, 1'b0, 1'b0, '0, '0, '{LAMPS_OFF, 1'b0, 1'b1}));
    directed_rows.push_back(row(ROW_KNOWN, 1'b1, 1'b0, '0, '0, '{LAMPS_OFF, 1'b0, 1'b1}));
    directed_rows.push_back(row(ROW_KNOWN, 1'b0, 1'b1, '0, '0, '{LAMPS_OFF, 1'b0, 1'b1}));
    directed_rows.push_back(row(ROW_KNOWN, 1'b1, 1'b1, '0, '0, '{LAMPS_YY, 1'b0, 1'b0}));
    directed_rows.push_back(row(ROW_WORD, 1'b1, 1'b1, '0, '0, '0));
    directed_rows.push_back(row(ROW_WORD, 1'b0, 1'b0, '0, '0, '0));
    directed_rows.push_back(row(ROW_WORD, 1'b1, 1'b0, '0, '0, '0));
    directed_rows.push_back(row(ROW_KNOWN, 1'b1, 1'b1, '0, '0, '{LAMPS_YY, 1'b0, 1'b0}));
    // lowest limits, plus a write past the last register
    directed_rows.push_back(row(ROW_CFG, 1'b0, 1'b0, REG_SHORT_TICKS, 16'd1, '0));
    directed_rows.push_back(row(ROW_CFG, 1'b0, 1'b0, REG_LONG_TICKS, 16'd1, '0));
    directed_rows.push_back(row(ROW_CFG, 1'b0, 1'b0, REG_FLASH_TICKS, 16'd1, '0));
    directed_rows.push_back(row(ROW_CFG, 1'b0, 1'b0, REG_HEARTBEAT_PERIOD, 16'd1, '0));
    directed_rows.push_back(row(ROW_CFG, 1'b0, 1'b0, REG_HEARTBEAT_ON, 16'd1, '0));
    directed_rows.push_back(row(ROW_CFG, 1'b0, 1'b0, REG_SPARE, 16'hFFFF, '0));
    // walk the full normal cycle, then flash, then restart
    repeat (9) directed_rows.push_back(row(ROW_WORD, 1'b1, 1'b1, '0, '0, '0));
    repeat (5) directed_rows.push_back(row(ROW_WORD, 1'b1, 1'b0, '0, '0, '0));
    directed_rows.push_back(row(ROW_WORD, 1'b1, 1'b1, '0, '0, '0));
    // limits of 65534, one below the largest register value
    directed_rows.push_back(row(ROW_CFG, 1'b0, 1'b0, REG_SHORT_TICKS, 16'd65534, '0));
    directed_rows.push_back(row(ROW_CFG, 1'b0, 1'b0, REG_LONG_TICKS, 16'd65534, '0));
    directed_rows.push_back(row(ROW_CFG, 1'b0, 1'b0, REG_FLASH_TICKS, 16'd65534, '0));
    directed_rows.push_back(row(ROW_CFG, 1'b0, 1'b0, REG_HEARTBEAT_PERIOD, 16'd65534, '0));
    directed_rows.push_back(row(ROW_CFG, 1'b0, 1'b0, REG_HEARTBEAT_ON, 16'd65534, '0));
    directed_rows.push_back(row(ROW_WORD, 1'b1, 1'b1, '0, '0, '0));
    directed_rows.push_back(row(ROW_WORD, 1'b0, 1'b1, '0, '0, '0));
    directed_rows.push_back(row(ROW_WORD, 1'b1, 1'b0, '0, '0, '0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    settled = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (!settled) begin
          wait_drained();
          settled = 1'b1;
          settings_used++;
        end
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        settled = 1'b0;
        send_word(directed_rows[i].tick, directed_rows[i].button,
                  directed_rows[i].kind == ROW_KNOWN, directed_rows[i].known);
      end
    end

    // random part over several limit settings
    load_settings(rand_lim(12), rand_lim(12), rand_lim(12), rand_lim(20), rand_lim(20));
    run_random(175, 1'b0);
    load_settings(16'd1, 16'd1, 16'd1, rand_lim(5), rand_lim(5));
    run_random(175, 1'b0);
    load_settings(rand_lim(8), rand_lim(8), rand_lim(8), rand_lim(15), rand_lim(15));
    run_random(175, 1'b1);
    load_settings(16'd65534, rand_lim(6), 16'd65534, rand_lim(10), rand_lim(10));
    run_random(175, 1'b0);
    load_settings(rand_lim(40), rand_lim(40), rand_lim(40), rand_lim(60), rand_lim(60));
    run_random(175, 1'b0);
    load_settings(rand_lim(12), rand_lim(12), rand_lim(12), rand_lim(20), rand_lim(20));
    run_random(170, 1'b0);

    wait_drained();
    $display("ran %0d words (%0d ticked) across %0d limit settings, directed rows then",
             words_sent, ticked_sent, settings_used);
    $display("random runs with stalls and a long hold; %0d results compared, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- traffic_light_sequencer.f -----
design/tls_pkg.sv
design/tls_cfg_regs.sv
design/tls_core.sv
design/traffic_light_sequencer.sv
tb/sv/tb_top.sv
